// File: hdl/rrhp_pkg.sv
// ----------------------------------------------------------------------------
// rrhp_pkg
// Types and constants shared by the RTP / RTCP header parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rrhp_pkg;

    // byte position counter width
    localparam int POS_W = 20;
    // control length in bytes: 4 * (length + 1)
    localparam int CLEN_W = 19;

    localparam logic [POS_W-1:0] POS_MAX      = {POS_W{1'b1}};
    localparam logic [POS_W-1:0] SEQ_END_POS  = POS_W'(3);
    localparam logic [POS_W-1:0] TS_END_POS   = POS_W'(7);
    localparam logic [POS_W-1:0] HDR_END_POS  = POS_W'(11);
    localparam logic [POS_W-1:0] RTCP_HDR_POS = POS_W'(3);
    localparam logic [POS_W:0]   MIN_PACKET   = (POS_W+1)'(12);
    localparam logic [CLEN_W-1:0] RTCP_WORD_BYTES = CLEN_W'(4);

    localparam logic [1:0] RTP_VERSION  = 2'd2;
    localparam logic [7:0] RTCP_TYPE_LO = 8'd200;
    localparam logic [7:0] RTCP_TYPE_HI = 8'd207;

    // output bus widths
    localparam int DATA_W = 136;
    localparam int USER_W = 5;

    typedef enum logic [1:0] {
        MODE_NONE = 2'd0,
        MODE_RTP  = 2'd1,
        MODE_RTCP = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        PH_FIXED       = 3'd0,
        PH_CSRC        = 3'd1,
        PH_EXT_HDR     = 3'd2,
        PH_EXT_WORD    = 3'd3,
        PH_PAYLOAD     = 3'd4,
        PH_RTCP_COVER  = 3'd5,
        PH_RTCP_BEYOND = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        KIND_RTP_HDR   = 3'd0,
        KIND_CSRC      = 3'd1,
        KIND_EXT_HDR   = 3'd2,
        KIND_EXT_WORD  = 3'd3,
        KIND_PAYLOAD   = 3'd4,
        KIND_RTCP_HDR  = 3'd5,
        KIND_RTCP_BYTE = 3'd6,
        KIND_END       = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        ST_CONTINUE = 2'd0,
        ST_SUCCESS  = 2'd1,
        ST_SHORT    = 2'd2,
        ST_INVALID  = 2'd3
    } t_status;

    // tdata fields, version in the lowest bits
    typedef struct packed {
        logic [31:0] value;
        logic [31:0] sync_source;
        logic [31:0] time_stamp;
        logic [15:0] sequence_res;
        logic [7:0]  type_code;
        logic        marker_bit;
        logic [3:0]  source_count;
        logic        extension_flag;
        logic        padding_flag;
        logic [1:0]  version;
    } t_payload;

    // tuser fields, kind in the lowest bits
    typedef struct packed {
        t_status status;
        t_kind   kind;
    } t_tag;

    typedef struct packed {
        t_tag     tag;
        t_payload payload;
    } t_result;

    localparam int PAD_W = DATA_W - $bits(t_payload);

endpackage

`default_nettype wire

// File: hdl/rrhp_front.sv
// ----------------------------------------------------------------------------
// rrhp_front
// Byte-level parser: tracks position and phase, builds at most one result per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module rrhp_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [7:0]        i_s_tdata,   // byte_value
    input  wire logic              i_s_tlast,   // last_byte
    input  wire logic              i_full,
    output logic                   o_push,
    output rrhp_pkg::t_result      o_result
);
    import rrhp_pkg::*;

    logic [POS_W-1:0]  r_pos,      n_pos;
    t_mode             r_mode,     n_mode;
    t_phase            r_phase,    n_phase;
    logic [31:0]       r_shift,    n_shift;
    logic [15:0]       r_first,    n_first;
    logic [15:0]       r_seq,      n_seq;
    logic [31:0]       r_ts,       n_ts;
    logic [3:0]        r_sources,  n_sources;
    logic [15:0]       r_ext_left, n_ext_left;
    logic [CLEN_W-1:0] r_clen,     n_clen;

    logic              w_accept;
    logic              w_have;
    logic              w_word_end;
    logic              w_rtcp_type;
    logic [CLEN_W-1:0] w_clen_calc;
    logic [POS_W:0]    w_pos_inc;
    t_phase            w_after_src;

    assign o_s_tready = !i_full;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign o_push     = w_accept && (w_have || i_s_tlast);

    // byte assembly and classification
    assign n_shift    = {r_shift[23:0], i_s_tdata};
    assign w_word_end = (r_pos[1:0] == 2'b11);
    assign w_pos_inc  = {1'b0, r_pos} + (POS_W+1)'(1);
    assign w_clen_calc = {{1'b0, n_shift[15:0]} + 17'd1, 2'b00};
    assign w_rtcp_type = (i_s_tdata >= RTCP_TYPE_LO) && (i_s_tdata <= RTCP_TYPE_HI);
    assign w_after_src = n_first[12] ? PH_EXT_HDR : PH_PAYLOAD;
    assign n_pos       = (r_pos != POS_MAX) ? w_pos_inc[POS_W-1:0] : r_pos;

    always_comb begin
        n_first = r_first;
        n_mode  = r_mode;
        if (r_pos == '0) begin
            n_first = {i_s_tdata, 8'h00};
        end else if (r_pos == POS_W'(1)) begin
            n_first = {r_first[15:8], i_s_tdata};
            n_mode  = (n_first[15:14] == RTP_VERSION && w_rtcp_type) ? MODE_RTCP : MODE_RTP;
        end
    end

    // next phase and counters
    always_comb begin
        n_phase    = r_phase;
        n_seq      = r_seq;
        n_ts       = r_ts;
        n_sources  = r_sources;
        n_ext_left = r_ext_left;
        n_clen     = r_clen;
        w_have     = 1'b0;
        if (n_mode == MODE_RTP) begin
            unique case (r_phase)
                PH_FIXED: begin
                    if (r_pos == SEQ_END_POS) begin
                        n_seq = n_shift[15:0];
                    end else if (r_pos == TS_END_POS) begin
                        n_ts = n_shift;
                    end else if (r_pos == HDR_END_POS) begin
                        w_have    = 1'b1;
                        n_sources = n_first[11:8];
                        n_phase   = (n_first[11:8] != 4'd0) ? PH_CSRC : w_after_src;
                    end
                end
                PH_CSRC: begin
                    if (w_word_end) begin
                        w_have    = 1'b1;
                        n_sources = r_sources - 4'd1;
                        if (n_sources == 4'd0) n_phase = w_after_src;
                    end
                end
                PH_EXT_HDR: begin
                    if (w_word_end) begin
                        w_have     = 1'b1;
                        n_ext_left = n_shift[15:0];
                        n_phase    = (n_shift[15:0] != 16'd0) ? PH_EXT_WORD : PH_PAYLOAD;
                    end
                end
                PH_EXT_WORD: begin
                    if (w_word_end) begin
                        w_have     = 1'b1;
                        n_ext_left = r_ext_left - 16'd1;
                        if (n_ext_left == 16'd0) n_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    w_have = 1'b1;
                end
                default: begin
                end
            endcase
        end else if (n_mode == MODE_RTCP) begin
            if (r_phase == PH_FIXED) begin
                if (r_pos == RTCP_HDR_POS) begin
                    w_have  = 1'b1;
                    n_clen  = w_clen_calc;
                    n_phase = (w_clen_calc > RTCP_WORD_BYTES) ? PH_RTCP_COVER : PH_RTCP_BEYOND;
                end
            end else if (r_phase == PH_RTCP_COVER) begin
                w_have = 1'b1;
                if (w_pos_inc >= (POS_W+1)'(r_clen)) n_phase = PH_RTCP_BEYOND;
            end
        end
    end

    // result item
    always_comb begin
        o_result = '0;
        if (n_mode == MODE_RTP) begin
            unique case (r_phase)
                PH_FIXED: begin
                    o_result.tag.kind               = KIND_RTP_HDR;
                    o_result.payload.version        = n_first[15:14];
                    o_result.payload.padding_flag   = n_first[13];
                    o_result.payload.extension_flag = n_first[12];
                    o_result.payload.source_count   = n_first[11:8];
                    o_result.payload.marker_bit     = n_first[7];
                    o_result.payload.type_code      = {1'b0, n_first[6:0]};
                    o_result.payload.sequence_res   = r_seq;
                    o_result.payload.time_stamp     = r_ts;
                    o_result.payload.sync_source    = n_shift;
                end
                PH_CSRC: begin
                    o_result.tag.kind      = KIND_CSRC;
                    o_result.payload.value = n_shift;
                end
                PH_EXT_HDR: begin
                    o_result.tag.kind             = KIND_EXT_HDR;
                    o_result.payload.sequence_res = n_shift[31:16];
                    o_result.payload.value        = {16'd0, n_shift[15:0]};
                end
                PH_EXT_WORD: begin
                    o_result.tag.kind      = KIND_EXT_WORD;
                    o_result.payload.value = n_shift;
                end
                PH_PAYLOAD: begin
                    o_result.tag.kind      = KIND_PAYLOAD;
                    o_result.payload.value = {24'd0, i_s_tdata};
                end
                default: begin
                end
            endcase
        end else if (n_mode == MODE_RTCP) begin
            if (r_phase == PH_FIXED) begin
                o_result.tag.kind          = KIND_RTCP_HDR;
                o_result.payload.version   = n_first[15:14];
                o_result.payload.type_code = n_first[7:0];
                o_result.payload.value     = {{(32-CLEN_W){1'b0}}, w_clen_calc};
            end else begin
                o_result.tag.kind      = KIND_RTCP_BYTE;
                o_result.payload.value = {24'd0, i_s_tdata};
            end
        end
        // final byte: end marker if no item completes, and the final status
        if (i_s_tlast) begin
            if (!w_have) begin
                o_result          = '0;
                o_result.tag.kind = KIND_END;
            end
            if (w_pos_inc < MIN_PACKET) begin
                o_result.tag.status = ST_SHORT;
            end else if (n_mode == MODE_RTP) begin
                o_result.tag.status = (n_phase == PH_PAYLOAD) ? ST_SUCCESS : ST_INVALID;
            end else begin
                o_result.tag.status = (n_phase == PH_RTCP_BEYOND) ? ST_SUCCESS : ST_INVALID;
            end
        end
    end

    // parser state, cleared at reset and after the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_accept && i_s_tlast)) begin
            r_pos      <= '0;
            r_mode     <= MODE_NONE;
            r_phase    <= PH_FIXED;
            r_shift    <= '0;
            r_first    <= '0;
            r_seq      <= '0;
            r_ts       <= '0;
            r_sources  <= '0;
            r_ext_left <= '0;
            r_clen     <= '0;
        end else if (w_accept) begin
            r_pos      <= n_pos;
            r_mode     <= n_mode;
            r_phase    <= n_phase;
            r_shift    <= n_shift;
            r_first    <= n_first;
            r_seq      <= n_seq;
            r_ts       <= n_ts;
            r_sources  <= n_sources;
            r_ext_left <= n_ext_left;
            r_clen     <= n_clen;
        end
    end

endmodule

`default_nettype wire

// File: hdl/rrhp_queue.sv
// ----------------------------------------------------------------------------
// rrhp_queue
// Small result queue between the parser front and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rrhp_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire rrhp_pkg::t_result i_data,
    output logic                   o_full,
    output logic                   o_valid,
    output rrhp_pkg::t_result      o_data,
    input  wire logic              i_pop
);
    import rrhp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_result           r_entry [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count,  n_count;

    logic w_push;
    logic w_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_data  = r_entry[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
        if (w_pop)  n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
        if (w_push && !w_pop) n_count = r_count + CNT_W'(1);
        else if (w_pop && !w_push) n_count = r_count - CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) r_entry[r_wr_ptr] <= i_data;
    end

endmodule

`default_nettype wire

// File: hdl/rrhp_back.sv
// ----------------------------------------------------------------------------
// rrhp_back
// Output register stage: drains the queue onto the master stream.
// ----------------------------------------------------------------------------
`default_nettype none

module rrhp_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire rrhp_pkg::t_result             i_data,
    output logic                               o_pop,
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // version, padding_flag, extension_flag, source_count, marker_bit,
    // type_code, sequence_res, time_stamp, sync_source, value (lsb up)
    output logic [rrhp_pkg::DATA_W-1:0]        o_m_tdata,
    // kind, status (lsb up)
    output logic [rrhp_pkg::USER_W-1:0]        o_m_tuser
);
    import rrhp_pkg::*;

    logic    r_valid;
    t_result r_res;
    logic    w_load;

    assign w_load = !r_valid || i_m_tready;
    assign o_pop  = i_valid && w_load;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_valid;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (o_pop) r_res <= i_data;
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {{PAD_W{1'b0}}, r_res.payload};
    assign o_m_tuser  = r_res.tag;

endmodule

`default_nettype wire

// File: hdl/rtp_rtcp_header_parser.sv
// ----------------------------------------------------------------------------
// rtp_rtcp_header_parser
// Streaming RTP / RTCP header parser, one packet byte in per cycle while o_s_tready is high.
// ----------------------------------------------------------------------------
// The block takes one packet byte per cycle and gives at most one result per
// byte, so it sustains one byte every clock while the output side keeps up.
// The byte parser builds a result in the cycle its byte is taken and writes
// it into the result queue; from the queue it moves into the output
// register, which drives the master stream. The queue holds QUEUE_DEPTH
// results; when the output side stalls and the queue is full, o_s_tready
// drops. The result of the last byte of a packet carries the final status.
`default_nettype none

module rtp_rtcp_header_parser #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic [7:0]                    i_s_tdata,   // byte_value
    input  wire logic                          i_s_tlast,   // last_byte
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // version[1:0], padding_flag[2], extension_flag[3], source_count[7:4],
    // marker_bit[8], type_code[16:9], sequence_res[32:17], time_stamp[64:33],
    // sync_source[96:65], value[128:97], zeros above
    output logic [rrhp_pkg::DATA_W-1:0]        o_m_tdata,
    // kind[2:0], status[4:3]
    output logic [rrhp_pkg::USER_W-1:0]        o_m_tuser
);
    import rrhp_pkg::*;

    logic    w_push;
    logic    w_full;
    logic    w_q_valid;
    logic    w_pop;
    t_result w_front_res;
    t_result w_q_res;

    // byte parser
    rrhp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_result   (w_front_res)
    );

    // result queue
    rrhp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_res),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_data  (w_q_res),
        .i_pop   (w_pop)
    );

    // output stage
    rrhp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_q_valid),
        .i_data     (w_q_res),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

`default_nettype wire

// File: hdl/rrhp_checker.sv
// ----------------------------------------------------------------------------
// rrhp_checker
// Port-level checks on the parser's result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rrhp_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    input  wire logic                          o_s_tready,
    input  wire logic [7:0]                    i_s_tdata,   // byte_value
    input  wire logic                          i_s_tlast,   // last_byte
    input  wire logic                          o_m_tvalid,
    input  wire logic                          i_m_tready,
    // version, padding, extension, source_count, marker, type_code,
    // sequence_res, time_stamp, sync_source, value (lsb up)
    input  wire logic [rrhp_pkg::DATA_W-1:0]   o_m_tdata,
    // kind, status (lsb up)
    input  wire logic [rrhp_pkg::USER_W-1:0]   o_m_tuser
);
    import rrhp_pkg::*;

    t_payload w_pl;
    t_tag     w_tag;
    logic     w_in_last;

    assign w_pl      = o_m_tdata[$bits(t_payload)-1:0];
    assign w_tag     = o_m_tuser;
    assign w_in_last = i_s_tvalid && o_s_tready && i_s_tlast && (i_s_tdata == i_s_tdata);

    // a stalled result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    // an end marker always carries a final status
    a_end_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && w_tag.kind == KIND_END |-> w_tag.status != ST_CONTINUE)
        else $error("end marker without final status");

    // rtp header item uses no value field
    a_hdr_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && w_tag.kind == KIND_RTP_HDR |-> w_pl.value == 32'd0)
        else $error("rtp header with nonzero value");

    // rtcp header item: byte length is a nonzero whole number of words, time stamp zero
    a_rtcp_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && w_tag.kind == KIND_RTCP_HDR |->
            w_pl.value[1:0] == 2'b00 && w_pl.value != 32'd0 && w_pl.time_stamp == 32'd0)
        else $error("bad rtcp header item");

    // a final byte taken with an empty, ready output side produces a valid result
    a_last_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_last && !o_m_tvalid && i_m_tready |=> ##1 o_m_tvalid)
        else $error("final byte produced no result");

endmodule

bind rtp_rtcp_header_parser rrhp_checker u_rrhp_checker (.*);

`default_nettype wire
